// File: src/assert_macros.svh
// Assertion helpers for the tilt filter checker.
// Both expect clk and rst_n to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ICTF_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ictf checker: property failed");

// Next-cycle implication.
`define ICTF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ictf checker: property failed");

`endif

// File: src/ictf_pkg.sv
package ictf_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int TAB_LEN         = 24;
    localparam int TAB_IDX_W       = 5;
    localparam int ANG_W           = 36;

    localparam logic signed [ANG_W-1:0] DEG_90  = 36'sd1509949440;
    localparam logic signed [ANG_W-1:0] DEG_180 = 36'sd3019898880;
    localparam logic signed [ANG_W-1:0] DEG_270 = 36'sd4529848320;
    localparam logic signed [ANG_W-1:0] DEG_360 = 36'sd6039797760;

    typedef enum logic [3:0] {
        CFG_GYRO_SCALE    = 4'd0,
        CFG_FILTER_WEIGHT = 4'd1,
        CFG_SAMPLE_PERIOD = 4'd2,
        CFG_MOUNT         = 4'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_G_MUL1,
        S_G_MUL2,
        S_G_DIVS,
        S_G_DIVW,
        S_G_ACC,
        S_C_INIT,
        S_C_STEP,
        S_C_END,
        S_B_MUL1,
        S_B_MUL2,
        S_B_SUM,
        S_B_ROUND,
        S_R_MUL,
        S_R_DIVS,
        S_R_DIVW,
        S_R_FIN,
        S_COMMIT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_G_MUL1,
        OP_G_MUL2,
        OP_G_DIV,
        OP_G_ACC,
        OP_C_INIT,
        OP_C_STEP,
        OP_C_END,
        OP_B_MUL1,
        OP_B_MUL2,
        OP_B_SUM,
        OP_B_ROUND,
        OP_R_MUL,
        OP_R_DIV,
        OP_R_FIN,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t                 op;
        logic [1:0]             axis;
        logic [TAB_IDX_W-1:0]   step;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic cor_special;
        logic first;
    } dp_status_t;

    // arctan(2^-i) in degrees, 24 fraction bits
    function automatic logic [29:0] atan_q24(input logic [TAB_IDX_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd754974720;
            5'd1:    v = 30'd445687602;
            5'd2:    v = 30'd235489088;
            5'd3:    v = 30'd119537938;
            5'd4:    v = 30'd60000934;
            5'd5:    v = 30'd30029717;
            5'd6:    v = 30'd15018523;
            5'd7:    v = 30'd7509720;
            5'd8:    v = 30'd3754917;
            5'd9:    v = 30'd1877466;
            5'd10:   v = 30'd938734;
            5'd11:   v = 30'd469367;
            5'd12:   v = 30'd234684;
            5'd13:   v = 30'd117342;
            5'd14:   v = 30'd58671;
            5'd15:   v = 30'd29335;
            5'd16:   v = 30'd14668;
            5'd17:   v = 30'd7334;
            5'd18:   v = 30'd3667;
            5'd19:   v = 30'd1833;
            5'd20:   v = 30'd917;
            5'd21:   v = 30'd458;
            5'd22:   v = 30'd229;
            5'd23:   v = 30'd115;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/ictf_div.sv
module ictf_div
    import ictf_pkg::*;
#(
    parameter int NUM_W = 50,
    parameter int DEN_W = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    always_comb
    begin
        rem_sh    = {rem_reg, quot_reg[NUM_W-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        fits      = rem_sh >= {1'b0, den_reg};
        rem_next  = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quot_next = {quot_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= num;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

// File: src/ictf_ctrl.sv
module ictf_ctrl
    import ictf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    state_t            state_reg, state_next;
    logic [1:0]        axis_reg, axis_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_G_MUL1;
                    axis_next  = 2'd0;
                end
            end
            S_G_MUL1: state_next = S_G_MUL2;
            S_G_MUL2: state_next = S_G_DIVS;
            S_G_DIVS: state_next = S_G_DIVW;
            S_G_DIVW:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_G_ACC;
                end
            end
            S_G_ACC:
            begin
                if (axis_reg == 2'd2)
                begin
                    state_next = S_C_INIT;
                    axis_next  = 2'd0;
                end
                else
                begin
                    state_next = S_G_MUL1;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            S_C_INIT:
            begin
                step_next  = '0;
                state_next = status.cor_special ? S_C_END : S_C_STEP;
            end
            S_C_STEP:
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_C_END;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_C_END:
            begin
                if (axis_reg == 2'd1)
                begin
                    state_next = S_B_MUL1;
                    axis_next  = 2'd0;
                end
                else
                begin
                    state_next = S_C_INIT;
                    axis_next  = 2'd1;
                end
            end
            S_B_MUL1: state_next = S_B_MUL2;
            S_B_MUL2: state_next = S_B_SUM;
            S_B_SUM:  state_next = S_B_ROUND;
            S_B_ROUND:
            begin
                if (!status.first)
                begin
                    state_next = S_R_MUL;
                end
                else if (axis_reg == 2'd1)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    state_next = S_B_MUL1;
                    axis_next  = 2'd1;
                end
            end
            S_R_MUL:  state_next = S_R_DIVS;
            S_R_DIVS: state_next = S_R_DIVW;
            S_R_DIVW:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_R_FIN;
                end
            end
            S_R_FIN:
            begin
                if (axis_reg == 2'd1)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    state_next = S_B_MUL1;
                    axis_next  = 2'd1;
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd.op         = OP_NONE;
        cmd.axis       = axis_reg;
        cmd.step       = TAB_IDX_W'(step_reg);
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_G_MUL1:  cmd.op = OP_G_MUL1;
            S_G_MUL2:  cmd.op = OP_G_MUL2;
            S_G_DIVS:  cmd.op = OP_G_DIV;
            S_G_ACC:   cmd.op = OP_G_ACC;
            S_C_INIT:  cmd.op = OP_C_INIT;
            S_C_STEP:  cmd.op = OP_C_STEP;
            S_C_END:   cmd.op = OP_C_END;
            S_B_MUL1:  cmd.op = OP_B_MUL1;
            S_B_MUL2:  cmd.op = OP_B_MUL2;
            S_B_SUM:   cmd.op = OP_B_SUM;
            S_B_ROUND: cmd.op = OP_B_ROUND;
            S_R_MUL:   cmd.op = OP_R_MUL;
            S_R_DIVS:  cmd.op = OP_R_DIV;
            S_R_FIN:   cmd.op = OP_R_FIN;
            S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_COMMIT;
                    out_valid_next = 1'b1;
                end
            end
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 2'd0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: src/ictf_dp.sv
module ictf_dp
    import ictf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [3:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic signed [31:0] filtered_angle_x,
    output logic signed [31:0] filtered_angle_y,
    output logic signed [31:0] rate_x,
    output logic signed [31:0] rate_y,
    output logic signed [31:0] integrated_x,
    output logic signed [31:0] integrated_y,
    output logic signed [31:0] integrated_z
);

    localparam int GYRO_RSH  = 20 - ANGLE_FRAC_BITS;
    localparam int GYRO_HALF = 1 << (GYRO_RSH - 1);
    localparam int ACC_RSH   = 24 - ANGLE_FRAC_BITS;
    localparam int ACC_HALF  = 1 << (ACC_RSH - 1);
    localparam int W_SHIFT   = 16;
    localparam int W_HALF    = 1 << (W_SHIFT - 1);

    localparam logic [23:0] CDIV_RECIP = 24'd8589935;
    localparam logic [22:0] CDIV_D     = 23'd125;

    function automatic logic signed [31:0] sat32(input logic signed [59:0] v);
        logic signed [31:0] r;
        if (v > 60'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -60'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic [23:0]        scale_reg;
    logic [16:0]        weight_reg;
    logic [9:0]         period_reg;
    logic               mount_reg;

    logic signed [15:0] g_reg [3];
    logic signed [15:0] acc_in_reg [3];
    logic signed [58:0] prod_reg;
    logic signed [59:0] sum_reg;
    logic               neg_reg;
    logic signed [36:0] d_reg [2];
    logic signed [31:0] gsum_reg [3];
    logic signed [35:0] cx_reg, cy_reg, cz_reg;
    logic signed [27:0] ang_reg [2];
    logic signed [31:0] fused_reg [2];
    logic signed [31:0] nf_reg [2];
    logic signed [31:0] rate_reg [2];
    logic               first_reg;

    logic signed [31:0] fx_out_reg, fy_out_reg, rx_out_reg, ry_out_reg;
    logic signed [31:0] ix_out_reg, iy_out_reg, iz_out_reg;

    logic [47:0]        cdiv_reg;
    logic [6:0]         crem_reg;
    logic [1:0]         ccnt_reg;
    logic               cbusy_reg;
    logic [49:0]        gdiv_num;
    logic [22:0]        cdiv_x;
    logic [46:0]        cdiv_prod;
    logic [15:0]        cdiv_q;
    logic [22:0]        cdiv_qd;
    logic [6:0]         cdiv_r;

    logic [9:0]         ms_eff;
    logic [16:0]        w_eff;
    logic [16:0]        w_comp;
    logic [23:0]        rate_den;

    logic signed [39:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [58:0] mul_p;

    logic signed [15:0] g_sel;
    logic signed [31:0] fused_sel, nf_sel, gsum_sel;
    logic signed [36:0] d_sel;
    logic signed [27:0] ang_sel;
    logic signed [37:0] bsum;
    logic signed [32:0] diff;

    logic [58:0]        prod_abs;
    logic               div_start;
    logic [49:0]        div_num;
    logic [23:0]        div_den;
    logic               div_busy;
    logic [49:0]        div_quot;

    logic [49:0]        rq;
    logic signed [36:0] d_new;
    logic signed [37:0] gsum_sum;
    logic signed [31:0] gsum_new;

    logic signed [15:0] cy_in, cx_in;
    logic               special;
    logic signed [35:0] special_z, z_init, x_ext, y_ext, x0, y0;
    logic signed [35:0] xs, ys, atan_v;

    logic signed [35:0] t1, t2, t;
    logic [35:0]        t_abs, t_q;
    logic signed [27:0] ang_new;

    logic [59:0]        s_abs, s_q;
    logic signed [59:0] n_val;
    logic signed [31:0] nf_new;
    logic signed [59:0] r_val;
    logic signed [31:0] rate_new;

    always_comb
    begin
        ms_eff   = (period_reg == 10'd0) ? 10'd1 : period_reg;
        w_eff    = (weight_reg > 17'd65536) ? 17'd65536 : weight_reg;
        w_comp   = 17'd65536 - w_eff;
        rate_den = 24'(ms_eff) * 24'd10000;
    end

    always_comb
    begin
        g_sel     = g_reg[cmd.axis];
        gsum_sel  = gsum_reg[cmd.axis];
        fused_sel = fused_reg[cmd.axis[0]];
        nf_sel    = nf_reg[cmd.axis[0]];
        d_sel     = d_reg[cmd.axis[0]];
        ang_sel   = ang_reg[cmd.axis[0]];
        bsum      = {{6{fused_sel[31]}}, fused_sel} + {d_sel[36], d_sel};
        diff      = {nf_sel[31], nf_sel} - {fused_sel[31], fused_sel};
    end

    always_comb
    begin
        case (cmd.op)
            OP_G_MUL1:
            begin
                mul_a = {16'd0, scale_reg};
                mul_b = {{3{g_sel[15]}}, g_sel};
            end
            OP_G_MUL2:
            begin
                mul_a = prod_reg[39:0];
                mul_b = {9'd0, ms_eff};
            end
            OP_B_MUL1:
            begin
                mul_a = {{2{bsum[37]}}, bsum};
                mul_b = {2'd0, w_eff};
            end
            OP_B_MUL2:
            begin
                mul_a = {{12{ang_sel[27]}}, ang_sel};
                mul_b = {2'd0, w_comp};
            end
            OP_R_MUL:
            begin
                mul_a = {{7{diff[32]}}, diff};
                mul_b = 19'sd174533;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        prod_abs  = prod_reg[58] ? 59'(-prod_reg) : prod_reg;
        gdiv_num  = prod_abs[49:0] + 50'd500;
        div_start = (cmd.op == OP_R_DIV);
        div_num   = prod_abs[49:0] + 50'(rate_den >> 1);
        div_den   = rate_den;
    end

    ictf_div #(
        .NUM_W (50),
        .DEN_W (24)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // divide by 1000 as a shift by 3 and then 125, 16 bits a cycle
    always_comb
    begin
        cdiv_x    = {crem_reg, cdiv_reg[47:32]};
        cdiv_prod = 47'(cdiv_x) * 47'(CDIV_RECIP);
        cdiv_q    = cdiv_prod[45:30];
        cdiv_qd   = 23'(cdiv_q) * CDIV_D;
        cdiv_r    = 7'(cdiv_x - cdiv_qd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cbusy_reg <= 1'b0;
            ccnt_reg  <= '0;
        end
        else if (cmd.op == OP_G_DIV)
        begin
            cbusy_reg <= 1'b1;
            ccnt_reg  <= 2'd3;
        end
        else if (cbusy_reg)
        begin
            ccnt_reg <= ccnt_reg - 2'd1;
            if (ccnt_reg == 2'd1)
            begin
                cbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_G_DIV)
        begin
            cdiv_reg <= {1'b0, gdiv_num[49:3]};
            crem_reg <= '0;
        end
        else if (cbusy_reg)
        begin
            cdiv_reg <= {cdiv_reg[31:0], cdiv_q};
            crem_reg <= cdiv_r;
        end
    end

    always_comb
    begin
        rq       = (50'(cdiv_reg) + 50'(GYRO_HALF)) >> GYRO_RSH;
        d_new    = neg_reg ? (37'd0 - rq[36:0]) : rq[36:0];
        gsum_sum = {{6{gsum_sel[31]}}, gsum_sel} + {d_new[36], d_new};
        gsum_new = sat32(60'(gsum_sum));
    end

    always_comb
    begin
        cy_in     = cmd.axis[0] ? acc_in_reg[2] : acc_in_reg[1];
        cx_in     = cmd.axis[0] ? acc_in_reg[0] : acc_in_reg[2];
        special   = (cy_in == 16'sd0) || (cx_in == 16'sd0);
        if (cy_in == 16'sd0)
        begin
            special_z = cx_in[15] ? DEG_180 : '0;
        end
        else
        begin
            special_z = cy_in[15] ? -DEG_90 : DEG_90;
        end
        x_ext  = 36'(cx_in);
        y_ext  = 36'(cy_in);
        x0     = cx_in[15] ? -x_ext : x_ext;
        y0     = cx_in[15] ? -y_ext : y_ext;
        if (cx_in[15])
        begin
            z_init = cy_in[15] ? -DEG_180 : DEG_180;
        end
        else
        begin
            z_init = '0;
        end
        xs     = cx_reg >>> cmd.step;
        ys     = cy_reg >>> cmd.step;
        atan_v = {6'd0, atan_q24(cmd.step)};
    end

    always_comb
    begin
        t1 = cz_reg + DEG_180;
        t2 = '0;
        if (cmd.axis[0] == 1'b0)
        begin
            if (mount_reg)
            begin
                t = (t1 > DEG_180) ? (t1 - DEG_360) : t1;
            end
            else
            begin
                t = cz_reg;
            end
        end
        else if (!mount_reg)
        begin
            t = (t1 > DEG_90) ? (t1 - DEG_270) : (t1 + DEG_90);
        end
        else
        begin
            t2 = t1 - DEG_90;
            t  = (t2 > DEG_180) ? (t2 - DEG_360) : t2;
        end
        t_abs   = t[35] ? 36'(-t) : t;
        t_q     = (t_abs + 36'(ACC_HALF)) >> ACC_RSH;
        ang_new = t[35] ? (28'd0 - t_q[27:0]) : t_q[27:0];
    end

    always_comb
    begin
        s_abs    = sum_reg[59] ? 60'(-sum_reg) : sum_reg;
        s_q      = (s_abs + 60'(W_HALF)) >> W_SHIFT;
        n_val    = sum_reg[59] ? (60'd0 - s_q) : s_q;
        nf_new   = sat32(n_val);
        r_val    = neg_reg ? (60'd0 - {10'd0, div_quot}) : {10'd0, div_quot};
        rate_new = sat32(r_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= 24'd73400;
            weight_reg <= 17'd64225;
            period_reg <= 10'd20;
            mount_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_GYRO_SCALE:    scale_reg  <= cfg_data;
                CFG_FILTER_WEIGHT: weight_reg <= cfg_data[16:0];
                CFG_SAMPLE_PERIOD: period_reg <= cfg_data[9:0];
                CFG_MOUNT:         mount_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsum_reg[0]  <= '0;
            gsum_reg[1]  <= '0;
            gsum_reg[2]  <= '0;
            fused_reg[0] <= '0;
            fused_reg[1] <= '0;
            first_reg    <= 1'b1;
        end
        else if (cmd.op == OP_G_ACC)
        begin
            gsum_reg[cmd.axis] <= gsum_new;
        end
        else if (cmd.op == OP_COMMIT)
        begin
            fused_reg[0] <= nf_reg[0];
            fused_reg[1] <= nf_reg[1];
            first_reg    <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                g_reg[0]      <= gyro_x;
                g_reg[1]      <= gyro_y;
                g_reg[2]      <= gyro_z;
                acc_in_reg[0] <= accel_x;
                acc_in_reg[1] <= accel_y;
                acc_in_reg[2] <= accel_z;
            end
            OP_G_MUL1, OP_G_MUL2, OP_B_MUL1, OP_R_MUL:
            begin
                prod_reg <= mul_p;
            end
            OP_B_MUL2:
            begin
                sum_reg  <= 60'(prod_reg);
                prod_reg <= mul_p;
            end
            OP_B_SUM:
            begin
                sum_reg <= sum_reg + 60'(prod_reg);
            end
            OP_G_DIV, OP_R_DIV:
            begin
                neg_reg <= prod_reg[58];
            end
            OP_G_ACC:
            begin
                if (cmd.axis != 2'd2)
                begin
                    d_reg[cmd.axis[0]] <= d_new;
                end
            end
            OP_C_INIT:
            begin
                cx_reg <= x0 <<< 14;
                cy_reg <= y0 <<< 14;
                cz_reg <= special ? special_z : z_init;
            end
            OP_C_STEP:
            begin
                if (!cy_reg[35])
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_v;
                end
            end
            OP_C_END:
            begin
                ang_reg[cmd.axis[0]] <= ang_new;
            end
            OP_B_ROUND:
            begin
                nf_reg[cmd.axis[0]] <= nf_new;
            end
            OP_R_FIN:
            begin
                rate_reg[cmd.axis[0]] <= rate_new;
            end
            OP_COMMIT:
            begin
                fx_out_reg <= nf_reg[0];
                fy_out_reg <= nf_reg[1];
                rx_out_reg <= first_reg ? 32'sd0 : rate_reg[0];
                ry_out_reg <= first_reg ? 32'sd0 : rate_reg[1];
                ix_out_reg <= gsum_reg[0];
                iy_out_reg <= gsum_reg[1];
                iz_out_reg <= gsum_reg[2];
            end
            default:
            begin
            end
        endcase
    end

    assign status.div_busy    = div_busy || cbusy_reg;
    assign status.cor_special = special;
    assign status.first       = first_reg;

    assign filtered_angle_x = fx_out_reg;
    assign filtered_angle_y = fy_out_reg;
    assign rate_x           = rx_out_reg;
    assign rate_y           = ry_out_reg;
    assign integrated_x     = ix_out_reg;
    assign integrated_y     = iy_out_reg;
    assign integrated_z     = iz_out_reg;

endmodule

// File: src/imu_tilt_complementary_filter_top.sv
// Tilt filter for one IMU: raw gyro and accelerometer counts in, fused
// pitch/roll, their rates and three integrated gyro angles out (Q16.16).
// Input channel: in_valid/in_ready carries one six-axis sample per transaction.
// Output channel: out_valid/out_ready carries the seven results of that sample.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// always ready; write only while no sample is in flight.
// One sample at a time: in_ready is high only when the block is idle.
// After a sample is accepted the block works out in turn the three gyro terms
// (divide by 1000 by reciprocal multiplication), the two arctangents by CORDIC
// (the steps are skipped when the vector lies on an axis), then for each tilt
// axis the blend and its rate on the radix-2 divider that both rates share (50
// bits, one bit a cycle). The first sample after reset skips the rates.
// A new sample can be accepted in the cycle after the result is registered.
// The result sits in an output register: a stalled receiver holds it, and
// the next sample is taken meanwhile; it waits at its end for the register.
// Reset restores the register defaults, clears the integrated and fused angles
// and marks the next sample as the first, whose rates read zero.
module imu_tilt_complementary_filter_top
    import ictf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] filtered_angle_x,
    output logic signed [31:0] filtered_angle_y,
    output logic signed [31:0] rate_x,
    output logic signed [31:0] rate_y,
    output logic signed [31:0] integrated_x,
    output logic signed [31:0] integrated_y,
    output logic signed [31:0] integrated_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    ictf_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    ictf_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .gyro_x           (gyro_x),
        .gyro_y           (gyro_y),
        .gyro_z           (gyro_z),
        .accel_x          (accel_x),
        .accel_y          (accel_y),
        .accel_z          (accel_z),
        .cmd              (cmd),
        .status           (status),
        .filtered_angle_x (filtered_angle_x),
        .filtered_angle_y (filtered_angle_y),
        .rate_x           (rate_x),
        .rate_y           (rate_y),
        .integrated_x     (integrated_x),
        .integrated_y     (integrated_y),
        .integrated_z     (integrated_z)
    );

endmodule

// File: src/ictf_checker.sv
`include "assert_macros.svh"

module ictf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] filtered_angle_x,
    input logic [31:0] rate_x,
    input logic [31:0] integrated_z
);

    `ICTF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    `ICTF_ASSERT_NEXT(a_no_result_at_accept, in_valid && in_ready, !$rose(out_valid))

    `ICTF_ASSERT_IMP(a_result_while_busy, $rose(out_valid), !$past(in_ready))

    `ICTF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered_angle_x) && $stable(rate_x) && $stable(integrated_z))

endmodule

bind imu_tilt_complementary_filter_top ictf_checker u_ictf_checker (.*);
